@@ hw/rtl/bpc_pkg.sv @@
// Shared types and constants for the button press classifier.
package bpc_pkg;

  localparam int TimeBitsDefault = 32;
  localparam int NowBits = 32;
  localparam int CfgBits = 16;
  localparam int CfgIndexBits = 2;
  localparam int InDataBits = 40;
  localparam int OutDataBits = 8;

  localparam logic [CfgBits-1:0] DebounceReset = 16'd30;
  localparam logic [CfgBits-1:0] WindowReset = 16'd500;
  localparam logic [CfgBits-1:0] LongReset = 16'd5000;

  localparam logic [CfgIndexBits-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CfgIndexBits-1:0] REG_WINDOW = 2'd1;
  localparam logic [CfgIndexBits-1:0] REG_LONG = 2'd2;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_INIT = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_SHORT = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG = 2'd3
  } event_t;

  typedef struct packed {
    logic [CfgBits-1:0] debounce_time;
    logic [CfgBits-1:0] double_press_window;
    logic [CfgBits-1:0] long_press_time;
  } cfg_t;

endpackage

@@ hw/rtl/bpc_cfg_regs.sv @@
// Configuration register bank for the button press classifier.
module bpc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bpc_pkg::CfgIndexBits-1:0]    cfg_index,
  input  logic [bpc_pkg::CfgBits-1:0]         cfg_wdata,
  output bpc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= bpc_pkg::DebounceReset;
      cfg.double_press_window <= bpc_pkg::WindowReset;
      cfg.long_press_time <= bpc_pkg::LongReset;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_DEBOUNCE: cfg.debounce_time <= cfg_wdata;
        bpc_pkg::REG_WINDOW:   cfg.double_press_window <= cfg_wdata;
        bpc_pkg::REG_LONG:     cfg.long_press_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/bpc_classifier.sv @@
// Debounce and press classification state with its next-state logic.
module bpc_classifier #(
  parameter int TIME_BITS = bpc_pkg::TimeBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        op,
  input  logic                        level,
  input  logic [bpc_pkg::NowBits-1:0] now_ms,
  input  bpc_pkg::cfg_t               cfg,
  output bpc_pkg::event_t             ev
);

  logic                 stable_level, stable_level_next;
  logic                 sampled_level, sampled_level_next;
  logic [TIME_BITS-1:0] sample_start_time, sample_start_time_next;
  logic [TIME_BITS-1:0] press_start_time, press_start_time_next;
  logic                 short_pending, short_pending_next;
  logic [TIME_BITS-1:0] release_time, release_time_next;
  logic                 long_reported, long_reported_next;

  logic [TIME_BITS+bpc_pkg::NowBits-1:0] now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS+bpc_pkg::CfgBits-1:0] deb_wide, win_wide, long_wide;
  logic [TIME_BITS-1:0] deb_t, win_t, long_t;
  logic [TIME_BITS-1:0] el_sample, el_press, el_release;

  assign now_wide = {{TIME_BITS{1'b0}}, now_ms};
  assign now_t = now_wide[TIME_BITS-1:0];
  assign deb_wide = {{TIME_BITS{1'b0}}, cfg.debounce_time};
  assign win_wide = {{TIME_BITS{1'b0}}, cfg.double_press_window};
  assign long_wide = {{TIME_BITS{1'b0}}, cfg.long_press_time};
  assign deb_t = deb_wide[TIME_BITS-1:0];
  assign win_t = win_wide[TIME_BITS-1:0];
  assign long_t = long_wide[TIME_BITS-1:0];

  assign el_sample = now_t - sample_start_time;
  assign el_press = now_t - press_start_time;
  assign el_release = now_t - release_time;

  always_comb begin
    ev = bpc_pkg::EV_NONE;
    stable_level_next = stable_level;
    sampled_level_next = sampled_level;
    sample_start_time_next = sample_start_time;
    press_start_time_next = press_start_time;
    short_pending_next = short_pending;
    release_time_next = release_time;
    long_reported_next = long_reported;
    if (op == bpc_pkg::OP_INIT) begin
      stable_level_next = level;
      sampled_level_next = level;
      sample_start_time_next = now_t;
      press_start_time_next = now_t;
      short_pending_next = 1'b0;
      release_time_next = '0;
      long_reported_next = 1'b0;
    end else if (level != sampled_level) begin
      sampled_level_next = level;
      sample_start_time_next = now_t;
    end else if (level != stable_level && el_sample >= deb_t) begin
      stable_level_next = level;
      if (level) begin
        press_start_time_next = now_t;
        long_reported_next = 1'b0;
        if (short_pending) begin
          short_pending_next = 1'b0;
          if (el_release <= win_t) begin
            long_reported_next = 1'b1;
            ev = bpc_pkg::EV_DOUBLE;
          end else begin
            ev = bpc_pkg::EV_SHORT;
          end
        end
      end else if (!long_reported) begin
        short_pending_next = 1'b1;
        release_time_next = now_t;
      end
    end else if (stable_level && !long_reported && el_press >= long_t) begin
      long_reported_next = 1'b1;
      ev = bpc_pkg::EV_LONG;
    end else if (!stable_level && !sampled_level && short_pending && el_release >= win_t) begin
      short_pending_next = 1'b0;
      ev = bpc_pkg::EV_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= 1'b0;
      sampled_level <= 1'b0;
      sample_start_time <= '0;
      press_start_time <= '0;
      short_pending <= 1'b0;
      release_time <= '0;
      long_reported <= 1'b0;
    end else if (en) begin
      stable_level <= stable_level_next;
      sampled_level <= sampled_level_next;
      sample_start_time <= sample_start_time_next;
      press_start_time <= press_start_time_next;
      short_pending <= short_pending_next;
      release_time <= release_time_next;
      long_reported <= long_reported_next;
    end
  end

  a_double_blocks_long: assert property (@(posedge clk) disable iff (rst)
    (en && ev == bpc_pkg::EV_DOUBLE) |=> (long_reported && stable_level && !short_pending))
    else $error("double press did not block the long press");

  a_long_once: assert property (@(posedge clk) disable iff (rst)
    (en && ev == bpc_pkg::EV_LONG) |=> long_reported)
    else $error("long press not recorded");

  a_short_clears: assert property (@(posedge clk) disable iff (rst)
    (en && ev == bpc_pkg::EV_SHORT) |=> !short_pending)
    else $error("short press left pending");

endmodule

@@ hw/rtl/button_press_classifier_core.sv @@
// Top level of the button press classifier: input and result registers around the classifier.
// An item moves from the input register into the result register once that register is free.
// Throughput: one item per cycle while the result side is ready.
// While a finished result waits, the input register takes one more item, then holds.
// Reset (rst, synchronous): stage valids clear, state and timestamps go to zero,
// registers load 30, 500 and 5000 ms.
module button_press_classifier_core #(
  parameter int TIME_BITS = bpc_pkg::TimeBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bpc_pkg::InDataBits-1:0]      s_tdata,   // pressed, now_ms, zero fill
  input  logic                                s_tuser,   // op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bpc_pkg::OutDataBits-1:0]     m_tdata,   // event_res, zero fill
  input  logic                                cfg_we,
  input  logic [bpc_pkg::CfgIndexBits-1:0]    cfg_index,
  input  logic [bpc_pkg::CfgBits-1:0]         cfg_wdata
);

  bpc_pkg::cfg_t   cfg;
  bpc_pkg::event_t ev;

  logic                        in_valid;
  logic                        in_op;
  logic                        in_pressed;
  logic [bpc_pkg::NowBits-1:0] in_now_ms;
  logic                        advance;
  logic [1:0]                  event_res;

  assign advance = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpc_classifier #(
    .TIME_BITS (TIME_BITS)
  ) u_classifier (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .op     (in_op),
    .level  (in_pressed),
    .now_ms (in_now_ms),
    .cfg    (cfg),
    .ev     (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op <= s_tuser;
      in_pressed <= s_tdata[0];
      in_now_ms <= s_tdata[bpc_pkg::NowBits:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res <= ev;
    end
  end

  assign m_tdata = {{(bpc_pkg::OutDataBits-2){1'b0}}, event_res};

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("staged item dropped before it advanced");

endmodule
